// ----- design/dxt5_block_decoder_core_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef DXT5_BLOCK_DECODER_CORE_MACROS_SVH
`define DXT5_BLOCK_DECODER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk and quiet while rst_n is low.
`define DXT5_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and quiet while rst_n is low.
`define DXT5_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/dxt5_pkg.sv -----
`timescale 1ns / 1ps

package dxt5_pkg;

    localparam int PIXELS     = 16;
    localparam int AIDX_BITS  = 3 * PIXELS;
    localparam int CIDX_BITS  = 2 * PIXELS;
    localparam logic [3:0] LAST_INDEX = 4'(PIXELS - 1);
    localparam logic [7:0] ALPHA_ZERO = 8'h00;
    localparam logic [7:0] ALPHA_FULL = 8'd255;

    // Load strobes for the three palette pipeline registers.
    typedef struct packed {
        logic raw;
        logic sum;
        logic pal;
    } stage_load_t;

    // Decoded codebooks plus the per-pixel indices of one block.
    typedef struct packed {
        logic [7:0][7:0]       alpha;
        logic [3:0][7:0]       blue;
        logic [3:0][7:0]       green;
        logic [3:0][7:0]       red;
        logic [AIDX_BITS-1:0]  alpha_idx;
        logic [CIDX_BITS-1:0]  color_idx;
    } palette_t;

    // Reciprocal multiplications, exact for every operand whose quotient fits in eight bits.
    function automatic logic [7:0] div3(input logic [10:0] x);
        logic [23:0] p;
        p = 24'(x) * 24'd683;
        return p[18:11];
    endfunction

    function automatic logic [7:0] div5(input logic [10:0] x);
        logic [23:0] p;
        p = 24'(x) * 24'd1639;
        return p[20:13];
    endfunction

    function automatic logic [7:0] div7(input logic [10:0] x);
        logic [23:0] p;
        p = 24'(x) * 24'd2341;
        return p[21:14];
    endfunction

endpackage

// ----- design/dxt5_palette.sv -----
`timescale 1ns / 1ps

module dxt5_palette (
    input  logic                   clk,
    input  dxt5_pkg::stage_load_t  load,
    input  logic [63:0]            alpha_bits,
    input  logic [63:0]            color_bits,
    output dxt5_pkg::palette_t     palette
);

    logic [63:0] alpha_raw_reg;
    logic [63:0] color_raw_reg;

    logic [7:0]        a0_reg, a1_reg;
    logic              a_gt_reg, a_gt_next;
    logic [5:0][10:0]  s7_reg, s7_next;
    logic [3:0][10:0]  s5_reg, s5_next;
    logic [1:0][2:0][7:0] cend_reg, cend_next;
    logic [1:0][2:0][9:0] csum_reg, csum_next;
    logic [dxt5_pkg::AIDX_BITS-1:0] aidx_reg;
    logic [dxt5_pkg::CIDX_BITS-1:0] cidx_reg;

    dxt5_pkg::palette_t palette_reg, palette_next;

    logic [7:0]  a0, a1;
    logic [15:0] e0, e1;

    assign a0 = alpha_raw_reg[7:0];
    assign a1 = alpha_raw_reg[15:8];
    assign e0 = color_raw_reg[15:0];
    assign e1 = color_raw_reg[31:16];

    // Weighted sums of the endpoints; the divides follow one register later.
    always_comb
    begin
        a_gt_next = a0 > a1;
        for (int k = 0; k < 6; k++)
        begin
            s7_next[k] = 11'(6 - k) * {3'b000, a0} + 11'(k + 1) * {3'b000, a1} + 11'd3;
        end
        for (int k = 0; k < 4; k++)
        begin
            s5_next[k] = 11'(4 - k) * {3'b000, a0} + 11'(k + 1) * {3'b000, a1} + 11'd2;
        end
        cend_next[0][0] = {e0[4:0], 3'b000};
        cend_next[0][1] = {e0[10:5], 2'b00};
        cend_next[0][2] = {e0[15:11], 3'b000};
        cend_next[1][0] = {e1[4:0], 3'b000};
        cend_next[1][1] = {e1[10:5], 2'b00};
        cend_next[1][2] = {e1[15:11], 3'b000};
        for (int c = 0; c < 3; c++)
        begin
            csum_next[0][c] = {1'b0, cend_next[0][c], 1'b0} + {2'b00, cend_next[1][c]} + 10'd1;
            csum_next[1][c] = {2'b00, cend_next[0][c]} + {1'b0, cend_next[1][c], 1'b0} + 10'd1;
        end
    end

    always_comb
    begin
        palette_next.alpha[0] = a0_reg;
        palette_next.alpha[1] = a1_reg;
        for (int k = 0; k < 6; k++)
        begin
            if (a_gt_reg)
            begin
                palette_next.alpha[k + 2] = dxt5_pkg::div7(s7_reg[k]);
            end
            else if (k < 4)
            begin
                palette_next.alpha[k + 2] = dxt5_pkg::div5(s5_reg[k]);
            end
            else if (k == 4)
            begin
                palette_next.alpha[k + 2] = dxt5_pkg::ALPHA_ZERO;
            end
            else
            begin
                palette_next.alpha[k + 2] = dxt5_pkg::ALPHA_FULL;
            end
        end
        palette_next.blue[0]  = cend_reg[0][0];
        palette_next.blue[1]  = cend_reg[1][0];
        palette_next.blue[2]  = dxt5_pkg::div3({1'b0, csum_reg[0][0]});
        palette_next.blue[3]  = dxt5_pkg::div3({1'b0, csum_reg[1][0]});
        palette_next.green[0] = cend_reg[0][1];
        palette_next.green[1] = cend_reg[1][1];
        palette_next.green[2] = dxt5_pkg::div3({1'b0, csum_reg[0][1]});
        palette_next.green[3] = dxt5_pkg::div3({1'b0, csum_reg[1][1]});
        palette_next.red[0]   = cend_reg[0][2];
        palette_next.red[1]   = cend_reg[1][2];
        palette_next.red[2]   = dxt5_pkg::div3({1'b0, csum_reg[0][2]});
        palette_next.red[3]   = dxt5_pkg::div3({1'b0, csum_reg[1][2]});
        palette_next.alpha_idx = aidx_reg;
        palette_next.color_idx = cidx_reg;
    end

    always_ff @(posedge clk)
    begin
        if (load.raw)
        begin
            alpha_raw_reg <= alpha_bits;
            color_raw_reg <= color_bits;
        end
        if (load.sum)
        begin
            a0_reg   <= a0;
            a1_reg   <= a1;
            a_gt_reg <= a_gt_next;
            s7_reg   <= s7_next;
            s5_reg   <= s5_next;
            cend_reg <= cend_next;
            csum_reg <= csum_next;
            aidx_reg <= alpha_raw_reg[63:16];
            cidx_reg <= color_raw_reg[63:32];
        end
        if (load.pal)
        begin
            palette_reg <= palette_next;
        end
    end

    assign palette = palette_reg;

endmodule

// ----- design/dxt5_block_decoder_core.sv -----
`timescale 1ns / 1ps
// Channel   Direction  Payload                                          Transaction marks
// s_axis    in         tdata: alpha_bits, color_bits                    one compressed block
// m_axis    out        tdata: pixel_index, blue, green, red, alpha      one pixel, tlast on 16th
// cfg       in         cfg_data: alpha_enable                           one register write
//
// Each block produces sixteen pixels, one per cycle while m_axis is not stalled; the single
// pixel output register sets the sustained block rate.
// A block passes through the input, sum, codebook and output registers in that order before
// its first pixel is presented. A new block is taken while the previous one is still
// emitting.
// Reset clears all valid flags and the pixel counter and sets alpha_enable to 1.
// A stall on m_axis holds the current pixel; upstream backs up through the pipeline.

module dxt5_block_decoder_core (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [63:0] alpha_bits, [127:64] color_bits
    input  logic [127:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [3:0] pixel_index, [11:4] blue, [19:12] green, [27:20] red, [35:28] alpha,
    // [39:36] zero fill
    output logic [39:0]  m_axis_tdata,
    output logic         m_axis_tlast,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_data
);

    // Pipeline occupancy: raw block, weighted sums, finished codebook, output pixel.
    logic raw_valid_reg,  raw_valid_next;
    logic sum_valid_reg,  sum_valid_next;
    logic pal_valid_reg,  pal_valid_next;
    logic out_valid_reg,  out_valid_next;
    logic [3:0] pixel_reg, pixel_next;
    logic alpha_en_reg,   alpha_en_next;

    logic [3:0] out_index_reg;
    logic [7:0] out_blue_reg, out_green_reg, out_red_reg, out_alpha_reg;
    logic       out_last_reg;

    dxt5_pkg::stage_load_t load;
    dxt5_pkg::palette_t    palette;

    logic       out_load;
    logic       pal_done;
    logic       s_accept;
    logic [1:0] cidx;
    logic [2:0] aidx;
    logic [5:0] apos;

    // A codebook is released when its sixteenth pixel moves into the output register.
    // Each earlier stage may load when the next one is empty or emptying this cycle.
    always_comb
    begin
        out_load = pal_valid_reg && (!out_valid_reg || m_axis_tready);
        pal_done = out_load && (pixel_reg == dxt5_pkg::LAST_INDEX);
        load.pal = sum_valid_reg && (!pal_valid_reg || pal_done);
        load.sum = raw_valid_reg && (!sum_valid_reg || load.pal);
        s_axis_tready = !raw_valid_reg || load.sum;
        s_accept = s_axis_tvalid && s_axis_tready;
        load.raw = s_accept;

        raw_valid_next = s_accept || (raw_valid_reg && !load.sum);
        sum_valid_next = load.sum || (sum_valid_reg && !load.pal);
        pal_valid_next = load.pal || (pal_valid_reg && !pal_done);
        out_valid_next = out_load || (out_valid_reg && !m_axis_tready);
        pixel_next     = out_load ? pixel_reg + 4'd1 : pixel_reg;
        alpha_en_next  = (cfg_valid && cfg_ready) ? cfg_data : alpha_en_reg;
    end

    dxt5_palette u_palette (
        .clk        (clk),
        .load       (load),
        .alpha_bits (s_axis_tdata[63:0]),
        .color_bits (s_axis_tdata[127:64]),
        .palette    (palette)
    );

    // Per-pixel index lookup: two color bits and three alpha bits per pixel.
    assign apos = {2'b00, pixel_reg} + {1'b0, pixel_reg, 1'b0};
    assign cidx = palette.color_idx[{pixel_reg, 1'b0} +: 2];
    assign aidx = palette.alpha_idx[apos +: 3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_valid_reg <= 1'b0;
            sum_valid_reg <= 1'b0;
            pal_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            pixel_reg     <= 4'd0;
            alpha_en_reg  <= 1'b1;
        end
        else
        begin
            raw_valid_reg <= raw_valid_next;
            sum_valid_reg <= sum_valid_next;
            pal_valid_reg <= pal_valid_next;
            out_valid_reg <= out_valid_next;
            pixel_reg     <= pixel_next;
            alpha_en_reg  <= alpha_en_next;
        end
    end

    // Output pixel register; holds its contents while the consumer stalls.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_index_reg <= pixel_reg;
            out_blue_reg  <= palette.blue[cidx];
            out_green_reg <= palette.green[cidx];
            out_red_reg   <= palette.red[cidx];
            out_alpha_reg <= alpha_en_reg ? palette.alpha[aidx] : dxt5_pkg::ALPHA_ZERO;
            out_last_reg  <= (pixel_reg == dxt5_pkg::LAST_INDEX);
        end
    end

    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000, out_alpha_reg, out_red_reg, out_green_reg,
                            out_blue_reg, out_index_reg};
    assign m_axis_tlast  = out_last_reg;

endmodule

// ----- design/dxt5_checker.sv -----
`timescale 1ns / 1ps
`include "dxt5_block_decoder_core_macros.svh"

module dxt5_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic [127:0] s_axis_tdata,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [39:0]  m_axis_tdata,
    input logic         m_axis_tlast,
    input logic         cfg_valid,
    input logic         cfg_ready,
    input logic         cfg_data
);

    // Pixel index the next output transaction should carry.
    logic [3:0] expect_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expect_reg <= 4'd0;
        end
        else if (m_axis_tvalid && m_axis_tready)
        begin
            expect_reg <= m_axis_tdata[3:0] + 4'd1;
        end
    end

    `DXT5_ASSERT_NOW(a_last_on_final_pixel, m_axis_tvalid,
        m_axis_tlast == (m_axis_tdata[3:0] == dxt5_pkg::LAST_INDEX),
        "tlast does not match the final pixel of the block")

    `DXT5_ASSERT_NOW(a_pixel_order, m_axis_tvalid, m_axis_tdata[3:0] == expect_reg,
        "pixel index out of row-major sequence")

    `DXT5_ASSERT_NEXT(a_stall_holds, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast),
        "output changed while stalled")

    // A waiting input block must stay put until the decoder takes it.
    `DXT5_ASSERT_NEXT(a_input_holds, s_axis_tvalid && !s_axis_tready,
        s_axis_tvalid && $stable(s_axis_tdata),
        "input block changed while waiting")

    // Register writes are taken at once; the user, not the decoder, must write only while no transaction is pending.
    `DXT5_ASSERT_NOW(a_cfg_when_idle, cfg_valid,
        cfg_ready && !s_axis_tvalid && !m_axis_tvalid && !$isunknown(cfg_data),
        "configuration write while a transaction is pending")

endmodule

bind dxt5_block_decoder_core dxt5_checker u_dxt5_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
);
